/* rtl/qrs_pkg.sv */
package qrs_pkg;

  // Width of every root field on the result port.
  localparam int ROOT_W = 35;

  // Per-item flags that ride along the pipeline.
  typedef struct packed {
    logic cplx;  // discriminant negative
    logic nq;    // coef_a was zero
  } qrs_flags_t;

endpackage

/* rtl/qrs_sqrt.sv */
// Pipelined floor square root, one result bit per stage (restoring, radix 4 digits).
module qrs_sqrt #(
  parameter int SW = 34,  // root bits; radicand is 2*SW bits
  parameter int TW = 8    // side data width
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_vld,
  input  logic [2*SW-1:0]       in_rad,
  input  qrs_pkg::qrs_flags_t   in_flags,
  input  logic [TW-1:0]         in_tag,
  output logic                  out_vld,
  output logic [SW-1:0]         out_root,
  output qrs_pkg::qrs_flags_t   out_flags,
  output logic [TW-1:0]         out_tag
);

  logic                vld_r   [0:SW-1];
  logic [2*SW-1:0]     rad_r   [0:SW-1];
  logic [SW+2:0]       rem_r   [0:SW-1];
  logic [SW-1:0]       q_r     [0:SW-1];
  qrs_pkg::qrs_flags_t flags_r [0:SW-1];
  logic [TW-1:0]       tag_r   [0:SW-1];

  for (genvar k = 0; k < SW; k++) begin : g_stage
    logic                src_vld;
    logic [2*SW-1:0]     src_rad;
    logic [SW+2:0]       src_rem;
    logic [SW-1:0]       src_q;
    qrs_pkg::qrs_flags_t src_flags;
    logic [TW-1:0]       src_tag;
    logic [SW+2:0]       rs;
    logic [SW+2:0]       trial;
    logic                take;

    if (k == 0) begin : g_first
      assign src_vld   = in_vld;
      assign src_rad   = in_rad;
      assign src_rem   = '0;
      assign src_q     = '0;
      assign src_flags = in_flags;
      assign src_tag   = in_tag;
    end else begin : g_next
      assign src_vld   = vld_r[k-1];
      assign src_rad   = rad_r[k-1];
      assign src_rem   = rem_r[k-1];
      assign src_q     = q_r[k-1];
      assign src_flags = flags_r[k-1];
      assign src_tag   = tag_r[k-1];
    end

    always_comb begin
      rs    = {src_rem[SW:0], src_rad[2*SW-1 -: 2]};
      trial = {1'b0, src_q, 2'b01};
      take  = (rs >= trial);
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_vld;
      end
      rad_r[k]   <= src_rad << 2;
      rem_r[k]   <= take ? (rs - trial) : rs;
      q_r[k]     <= {src_q[SW-2:0], take};
      flags_r[k] <= src_flags;
      tag_r[k]   <= src_tag;
    end
  end

  assign out_vld   = vld_r[SW-1];
  assign out_root  = q_r[SW-1];
  assign out_flags = flags_r[SW-1];
  assign out_tag   = tag_r[SW-1];

endmodule

/* rtl/qrs_div.sv */
// Two-lane pipelined restoring divider, unsigned, shared divisor, one quotient bit per stage.
module qrs_div #(
  parameter int MW = 34,  // numerator and quotient bits
  parameter int DW = 17,  // divisor bits
  parameter int TW = 2    // side data width
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_vld,
  input  logic [MW-1:0]       in_num1,
  input  logic [MW-1:0]       in_num2,
  input  logic [DW-1:0]       in_den,
  input  qrs_pkg::qrs_flags_t in_flags,
  input  logic [TW-1:0]       in_tag,
  output logic                out_vld,
  output logic [MW-1:0]       out_quo1,
  output logic [MW-1:0]       out_quo2,
  output qrs_pkg::qrs_flags_t out_flags,
  output logic [TW-1:0]       out_tag
);

  logic                vld_r   [0:MW-1];
  logic [MW-1:0]       num_r   [0:MW-1][0:1];
  logic [DW-1:0]       rem_r   [0:MW-1][0:1];
  logic [MW-1:0]       quo_r   [0:MW-1][0:1];
  logic [DW-1:0]       den_r   [0:MW-1];
  qrs_pkg::qrs_flags_t flags_r [0:MW-1];
  logic [TW-1:0]       tag_r   [0:MW-1];

  for (genvar k = 0; k < MW; k++) begin : g_stage
    logic                src_vld;
    logic [MW-1:0]       src_num [0:1];
    logic [DW-1:0]       src_rem [0:1];
    logic [MW-1:0]       src_quo [0:1];
    logic [DW-1:0]       src_den;
    qrs_pkg::qrs_flags_t src_flags;
    logic [TW-1:0]       src_tag;
    logic [DW:0]         rs      [0:1];
    logic                take    [0:1];

    if (k == 0) begin : g_first
      assign src_vld    = in_vld;
      assign src_num[0] = in_num1;
      assign src_num[1] = in_num2;
      assign src_rem[0] = '0;
      assign src_rem[1] = '0;
      assign src_quo[0] = '0;
      assign src_quo[1] = '0;
      assign src_den    = in_den;
      assign src_flags  = in_flags;
      assign src_tag    = in_tag;
    end else begin : g_next
      assign src_vld    = vld_r[k-1];
      assign src_num[0] = num_r[k-1][0];
      assign src_num[1] = num_r[k-1][1];
      assign src_rem[0] = rem_r[k-1][0];
      assign src_rem[1] = rem_r[k-1][1];
      assign src_quo[0] = quo_r[k-1][0];
      assign src_quo[1] = quo_r[k-1][1];
      assign src_den    = den_r[k-1];
      assign src_flags  = flags_r[k-1];
      assign src_tag    = tag_r[k-1];
    end

    always_comb begin
      for (int l = 0; l < 2; l++) begin
        rs[l]   = {src_rem[l], src_num[l][MW-1]};
        take[l] = (rs[l] >= {1'b0, src_den});
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else begin
        vld_r[k] <= src_vld;
      end
      for (int l = 0; l < 2; l++) begin
        num_r[k][l] <= src_num[l] << 1;
        rem_r[k][l] <= take[l] ? DW'(rs[l] - {1'b0, src_den}) : DW'(rs[l]);
        quo_r[k][l] <= {src_quo[l][MW-2:0], take[l]};
      end
      den_r[k]   <= src_den;
      flags_r[k] <= src_flags;
      tag_r[k]   <= src_tag;
    end
  end

  assign out_vld   = vld_r[MW-1];
  assign out_quo1  = quo_r[MW-1][0];
  assign out_quo2  = quo_r[MW-1][1];
  assign out_flags = flags_r[MW-1];
  assign out_tag   = tag_r[MW-1];

endmodule

/* rtl/quadratic_root_solver_unit.sv */
// Channel  | Ports                                         | Transfer
// ---------+-----------------------------------------------+---------------------------
// input    | start, busy, in_coef_a/b/c                    | start & !busy at clk edge
// result   | out_valid, out_first_*/out_second_*, out_*    | out_valid one cycle, no hold
//
// Cycles: one item enters per clock; busy is always low. The pipe runs
//   stage 1, stage 2, SW sqrt stages, SW = COEF_WIDTH+FRAC_BITS+1 (root bits,
//   one sqrt stage each), stage 3, MW divider stages, MW = COEF_WIDTH+FRAC_BITS+2
//   (quotient bits, one divider stage each), then the output register.
// Reset: rst_n (sync, active low) clears only the valid bits of each stage.
// Stalls: none; the receiver cannot hold off results and the pipe never stops.
module quadratic_root_solver_unit #(
  parameter int COEF_WIDTH = 16,
  parameter int FRAC_BITS  = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [COEF_WIDTH-1:0]        in_coef_a,
  input  logic signed [COEF_WIDTH-1:0]        in_coef_b,
  input  logic signed [COEF_WIDTH-1:0]        in_coef_c,
  output logic                                out_valid,
  output logic signed [qrs_pkg::ROOT_W-1:0]   out_first_real,
  output logic signed [qrs_pkg::ROOT_W-1:0]   out_first_imag,
  output logic signed [qrs_pkg::ROOT_W-1:0]   out_second_real,
  output logic signed [qrs_pkg::ROOT_W-1:0]   out_second_imag,
  output logic                                out_complex_roots,
  output logic                                out_not_quadratic
);

  localparam int W    = COEF_WIDTH;
  localparam int F    = FRAC_BITS;
  localparam int DW   = 2*W + 2;      // signed discriminant
  localparam int MAGW = DW - 1;       // |discriminant|
  localparam int SW   = W + F + 1;    // root bits
  localparam int NBW  = W + F + 1;    // -b scaled, signed
  localparam int AW   = W + 1;        // 2a, signed
  localparam int NW   = W + F + 3;    // numerator, signed
  localparam int MW   = NW - 1;       // numerator magnitude
  localparam int TW   = NBW + AW;
  localparam int RW   = qrs_pkg::ROOT_W;
  localparam int LAT  = 2 + SW + 1 + MW + 1;

  // Never stalls: a new transfer can be taken on every clock.
  assign busy = 1'b0;

  logic in_xfer;
  assign in_xfer = start & ~busy;

  // ---- stage 1: products ----
  logic                 s1_vld_r;
  logic signed [2*W-1:0] s1_bb_r, s1_ac_r;
  logic signed [W-1:0]  s1_a_r, s1_b_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_xfer;
    end
    s1_bb_r <= in_coef_b * in_coef_b;
    s1_ac_r <= in_coef_a * in_coef_c;
    s1_a_r  <= in_coef_a;
    s1_b_r  <= in_coef_b;
  end

  // ---- stage 2: discriminant, magnitude, scaled -b, 2a ----
  logic signed [DW-1:0]  disc_nxt;
  logic [MAGW-1:0]       mag_nxt;
  logic signed [NBW-1:0] nb_nxt;
  logic signed [AW-1:0]  twoa_nxt;

  always_comb begin
    disc_nxt = DW'(s1_bb_r) - (DW'(s1_ac_r) <<< 2);
    mag_nxt  = disc_nxt[DW-1] ? MAGW'(-disc_nxt) : MAGW'(disc_nxt);
    nb_nxt   = (-NBW'(s1_b_r)) <<< F;
    twoa_nxt = AW'(s1_a_r) <<< 1;
  end

  logic                  s2_vld_r;
  logic [MAGW-1:0]       s2_mag_r;
  qrs_pkg::qrs_flags_t   s2_flags_r;
  logic signed [NBW-1:0] s2_nb_r;
  logic signed [AW-1:0]  s2_twoa_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    s2_mag_r        <= mag_nxt;
    s2_flags_r.cplx <= disc_nxt[DW-1];
    s2_flags_r.nq   <= (s1_a_r == '0);
    s2_nb_r         <= nb_nxt;
    s2_twoa_r       <= twoa_nxt;
  end

  // ---- square root of |D| * 4^F ----
  logic                sq_vld;
  logic [SW-1:0]       sq_root;
  qrs_pkg::qrs_flags_t sq_flags;
  logic [TW-1:0]       sq_tag;

  qrs_sqrt #(.SW(SW), .TW(TW)) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s2_vld_r),
    .in_rad    ({1'b0, s2_mag_r, {(2*F){1'b0}}}),
    .in_flags  (s2_flags_r),
    .in_tag    ({s2_nb_r, s2_twoa_r}),
    .out_vld   (sq_vld),
    .out_root  (sq_root),
    .out_flags (sq_flags),
    .out_tag   (sq_tag)
  );

  // ---- stage 3: numerators and signs ----
  logic signed [NBW-1:0] sq_nb;
  logic signed [AW-1:0]  sq_twoa;
  logic signed [NW-1:0]  nbx, sx, n1, n2;
  logic [MW-1:0]         m1_nxt, m2_nxt;
  logic [AW-1:0]         den_nxt;

  always_comb begin
    sq_nb   = $signed(sq_tag[TW-1 -: NBW]);
    sq_twoa = $signed(sq_tag[AW-1:0]);
    nbx     = NW'(sq_nb);
    sx      = $signed(NW'(sq_root));
    // complex: lane 1 gives the real part, lane 2 the imaginary part
    n1      = sq_flags.cplx ? nbx : nbx + sx;
    n2      = sq_flags.cplx ? sx  : nbx - sx;
    m1_nxt  = n1[NW-1] ? MW'(-n1) : MW'(n1);
    m2_nxt  = n2[NW-1] ? MW'(-n2) : MW'(n2);
    den_nxt = sq_twoa[AW-1] ? AW'(-sq_twoa) : AW'(sq_twoa);
  end

  logic                s3_vld_r;
  logic [MW-1:0]       s3_m1_r, s3_m2_r;
  logic [AW-1:0]       s3_den_r;
  qrs_pkg::qrs_flags_t s3_flags_r;
  logic [1:0]          s3_sgn_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= sq_vld;
    end
    s3_m1_r    <= m1_nxt;
    s3_m2_r    <= m2_nxt;
    s3_den_r   <= den_nxt;
    s3_flags_r <= sq_flags;
    s3_sgn_r   <= {n1[NW-1] ^ sq_twoa[AW-1], n2[NW-1] ^ sq_twoa[AW-1]};
  end

  // ---- magnitude division, both lanes ----
  logic                dv_vld;
  logic [MW-1:0]       dv_q1, dv_q2;
  qrs_pkg::qrs_flags_t dv_flags;
  logic [1:0]          dv_sgn;

  qrs_div #(.MW(MW), .DW(AW), .TW(2)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_vld    (s3_vld_r),
    .in_num1   (s3_m1_r),
    .in_num2   (s3_m2_r),
    .in_den    (s3_den_r),
    .in_flags  (s3_flags_r),
    .in_tag    (s3_sgn_r),
    .out_vld   (dv_vld),
    .out_quo1  (dv_q1),
    .out_quo2  (dv_q2),
    .out_flags (dv_flags),
    .out_tag   (dv_sgn)
  );

  // ---- output stage: apply signs (truncation toward zero), select fields ----
  logic signed [MW:0]   q1s, q2s;
  logic signed [RW-1:0] r1, r2;

  always_comb begin
    q1s = dv_sgn[1] ? -$signed({1'b0, dv_q1}) : $signed({1'b0, dv_q1});
    q2s = dv_sgn[0] ? -$signed({1'b0, dv_q2}) : $signed({1'b0, dv_q2});
    r1  = RW'(q1s);
    r2  = RW'(q2s);
  end

  logic                 out_valid_r;
  logic signed [RW-1:0] fr_r, fi_r, sr_r, si_r;
  logic                 cplx_r, nq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= dv_vld;
    end
    nq_r <= dv_flags.nq;
    if (dv_flags.nq) begin
      fr_r   <= '0;
      fi_r   <= '0;
      sr_r   <= '0;
      si_r   <= '0;
      cplx_r <= 1'b0;
    end else if (dv_flags.cplx) begin
      fr_r   <= r1;
      fi_r   <= r2;
      sr_r   <= r1;
      si_r   <= -r2;
      cplx_r <= 1'b1;
    end else begin
      fr_r   <= r1;
      fi_r   <= '0;
      sr_r   <= r2;
      si_r   <= '0;
      cplx_r <= 1'b0;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_first_real    = fr_r;
  assign out_first_imag    = fi_r;
  assign out_second_real   = sr_r;
  assign out_second_imag   = si_r;
  assign out_complex_roots = cplx_r;
  assign out_not_quadratic = nq_r;

  // ---- assertions ----
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_xfer, LAT))
    else $error("result without matching input transfer");

  a_nq_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_not_quadratic) |->
      (out_first_real == '0 && out_first_imag == '0 && out_second_real == '0 &&
       out_second_imag == '0 && !out_complex_roots))
    else $error("not_quadratic result with nonzero fields");

  a_conj: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_complex_roots) |->
      (out_first_real == out_second_real && out_second_imag == -out_first_imag))
    else $error("complex roots not conjugate");

  a_real_imag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_complex_roots) |->
      (out_first_imag == '0 && out_second_imag == '0))
    else $error("real roots with imaginary part");

endmodule

/* test/quadratic_root_solver_unit_test.sv */
module quadratic_root_solver_unit_test;

  localparam int CW = 16;
  localparam int FB = 16;
  localparam int LATENCY = 71;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int N_RANDOM = 530;

  typedef struct {
    logic signed [CW-1:0] a;
    logic signed [CW-1:0] b;
    logic signed [CW-1:0] c;
  } coefs_t;

  typedef struct {
    logic signed [qrs_pkg::ROOT_W-1:0] first_real;
    logic signed [qrs_pkg::ROOT_W-1:0] first_imag;
    logic signed [qrs_pkg::ROOT_W-1:0] second_real;
    logic signed [qrs_pkg::ROOT_W-1:0] second_imag;
    logic complex_roots;
    logic not_quadratic;
  } roots_t;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic signed [CW-1:0] in_coef_a, in_coef_b, in_coef_c;
  logic out_valid;
  logic signed [qrs_pkg::ROOT_W-1:0] out_first_real, out_first_imag;
  logic signed [qrs_pkg::ROOT_W-1:0] out_second_real, out_second_imag;
  logic out_complex_roots, out_not_quadratic;

  coefs_t pending_coefs[$];
  roots_t expected_roots[$];
  int errors;
  int idle_cycles;
  bit stim_done;

  quadratic_root_solver_unit #(.COEF_WIDTH(CW), .FRAC_BITS(FB)) i_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_coef_a(in_coef_a), .in_coef_b(in_coef_b), .in_coef_c(in_coef_c),
    .out_valid(out_valid),
    .out_first_real(out_first_real), .out_first_imag(out_first_imag),
    .out_second_real(out_second_real), .out_second_imag(out_second_imag),
    .out_complex_roots(out_complex_roots), .out_not_quadratic(out_not_quadratic)
  );

  // floor(sqrt(m * 4^FB)), digit by digit, two radicand bits per step
  function automatic longint unsigned frac_sqrt(longint unsigned m);
    longint unsigned rem;
    longint unsigned root;
    longint unsigned trial;
    longint unsigned pair;
    rem = 0;
    root = 0;
    for (int i = 31 + FB; i >= 0; i--) begin
      pair = 0;
      if (i >= FB) pair = (m >> (2 * (i - FB))) & 64'd3;
      rem = (rem << 2) | pair;
      trial = (root << 2) | 64'd1;
      if (rem >= trial) begin
        rem = rem - trial;
        root = (root << 1) | 64'd1;
      end else begin
        root = root << 1;
      end
    end
    return root;
  endfunction

  function automatic roots_t solve_roots(coefs_t k);
    roots_t r;
    longint a, b, c, disc, s, two_a, nb, re, im, neg_im;
    r = '{default: '0};
    a = k.a;
    b = k.b;
    c = k.c;
    if (a == 0) begin
      r.not_quadratic = 1'b1;
      return r;
    end
    disc = b * b - 4 * a * c;
    s = longint'(frac_sqrt(disc < 0 ? -disc : disc));
    two_a = 2 * a;
    nb = -b * (64'sd1 <<< FB);
    // SV integer division truncates toward zero, matching the block
    if (disc < 0) begin
      re = nb / two_a;
      im = s / two_a;
      neg_im = -im;
      r.first_real = re[qrs_pkg::ROOT_W-1:0];
      r.first_imag = im[qrs_pkg::ROOT_W-1:0];
      r.second_real = re[qrs_pkg::ROOT_W-1:0];
      r.second_imag = neg_im[qrs_pkg::ROOT_W-1:0];
      r.complex_roots = 1'b1;
    end else begin
      re = (nb + s) / two_a;
      im = (nb - s) / two_a;
      r.first_real = re[qrs_pkg::ROOT_W-1:0];
      r.second_real = im[qrs_pkg::ROOT_W-1:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $realtime);
    errors++;
  endtask

  function automatic logic signed [CW-1:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      1: return '0;
      2: return $signed(16'($urandom_range(0, 16)) - 16'sd8);
      3: return $signed(16'($urandom_range(0, 512)) - 16'sd256);
      default: return $signed(16'($urandom));
    endcase
  endfunction

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // stimulus: extremes, each root kind, degenerate a, then random coefficients
  initial begin
    logic signed [CW-1:0] ext[4];
    coefs_t k;
    ext = '{16'sh8000, 16'sh7fff, 16'sd0, -16'sd1};
    foreach (ext[i]) foreach (ext[j]) begin
      k.a = ext[i];
      k.b = ext[j];
      k.c = ext[(i + j) % 4];
      pending_coefs.push_back(k);
    end
    pending_coefs.push_back('{1, -3, 2});      // two real roots
    pending_coefs.push_back('{1, 2, 1});       // double root
    pending_coefs.push_back('{1, 0, 1});       // purely imaginary
    pending_coefs.push_back('{-3, 5, -7});     // complex, negative a
    pending_coefs.push_back('{2, 7, 3});       // two real roots, exact, one fractional
    pending_coefs.push_back('{16'sh8000, 16'sh7fff, 16'sh7fff});
    for (int n = 0; n < N_RANDOM; n++) begin
      k.a = rand_coef();
      k.b = rand_coef();
      k.c = rand_coef();
      pending_coefs.push_back(k);
    end
  end

  // driver: random gap before each item, start held while busy
  int gap;
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      start <= 1'b0;
      in_coef_a <= '0;
      in_coef_b <= '0;
      in_coef_c <= '0;
      gap <= $urandom_range(0, 7);
    end else if (start && !busy) begin
      expected_roots.push_back(solve_roots('{in_coef_a, in_coef_b, in_coef_c}));
      void'(pending_coefs.pop_front());
      if (pending_coefs.size() == 0) begin
        start <= 1'b0;
        stim_done <= 1'b1;
      end else begin
        draw = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        if (draw == 0) begin
          in_coef_a <= pending_coefs[0].a;
          in_coef_b <= pending_coefs[0].b;
          in_coef_c <= pending_coefs[0].c;
        end else begin
          start <= 1'b0;
          gap <= draw;
        end
      end
    end else if (!start && pending_coefs.size() != 0) begin
      if (gap > 0) begin
        gap <= gap - 1;
      end else begin
        start <= 1'b1;
        in_coef_a <= pending_coefs[0].a;
        in_coef_b <= pending_coefs[0].b;
        in_coef_c <= pending_coefs[0].c;
      end
    end
  end

  // monitor: each strobe transfer checked against the oldest expectation
  always @(posedge clk) begin
    roots_t want;
    if (rst_n && out_valid) begin
      if (expected_roots.size() == 0) begin
        $display("unexpected result at %0t", $realtime);
        errors++;
      end else begin
        want = expected_roots.pop_front();
        if (out_first_real !== want.first_real)
          report_mismatch("first_real", out_first_real, want.first_real);
        if (out_first_imag !== want.first_imag)
          report_mismatch("first_imag", out_first_imag, want.first_imag);
        if (out_second_real !== want.second_real)
          report_mismatch("second_real", out_second_real, want.second_real);
        if (out_second_imag !== want.second_imag)
          report_mismatch("second_imag", out_second_imag, want.second_imag);
        if (out_complex_roots !== want.complex_roots)
          report_mismatch("complex_roots", out_complex_roots, want.complex_roots);
        if (out_not_quadratic !== want.not_quadratic)
          report_mismatch("not_quadratic", out_not_quadratic, want.not_quadratic);
      end
    end
  end

  // watchdog: cycles without any transfer on either side
  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
  end

  initial begin
    rst_n = 0;
    repeat (3) @(posedge clk);
    rst_n <= 1;
    while (!(stim_done && expected_roots.size() == 0) && idle_cycles < WATCHDOG_LIMIT)
      @(posedge clk);
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("FAILURE");
    end else begin
      // drain window for stray strobes
      repeat (LATENCY + 10) @(posedge clk);
      if (errors == 0) begin
        $display("SUCCESS");
      end else begin
        $display("FAILURE");
      end
    end
    $finish;
  end

endmodule
